/* rtl/dhp_pkg.sv */
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types, codes and lookup functions of the DDS header parser.
// ----------------------------------------------------------------------------
package dhp_pkg;

    localparam int QueueDepth = 4;

    localparam logic [31:0] FccMagic = 32'h2053_4444;  // "DDS "
    localparam logic [31:0] FccDx10  = 32'h3031_5844;  // "DX10"
    localparam logic [31:0] FccDxt1  = 32'h3154_5844;
    localparam logic [31:0] FccDxt2  = 32'h3254_5844;
    localparam logic [31:0] FccDxt3  = 32'h3354_5844;
    localparam logic [31:0] FccDxt4  = 32'h3454_5844;
    localparam logic [31:0] FccDxt5  = 32'h3554_5844;
    localparam logic [31:0] FccDxt7  = 32'h3754_5844;
    localparam logic [31:0] FccBc4u  = 32'h5534_4342;
    localparam logic [31:0] FccBc5u  = 32'h5535_4342;
    localparam logic [31:0] FlagFourcc = 32'h0000_0004;
    localparam logic [31:0] DimTex2d   = 32'd3;
    localparam logic [31:0] HeaderSize = 32'd124;
    localparam logic [31:0] FormatSize = 32'd32;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_MAGIC     = 4'd1,
        ST_HDR_SIZE  = 4'd2,
        ST_PF_SIZE   = 4'd3,
        ST_NO_FOURCC = 4'd4,
        ST_NOT_2D    = 4'd5,
        ST_FORMAT    = 4'd6,
        ST_DIMS      = 4'd7,
        ST_TRUNC     = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        CT_UNKNOWN = 3'd0,
        CT_BC1     = 3'd1,
        CT_BC2     = 3'd2,
        CT_BC3     = 3'd3,
        CT_BC4     = 3'd4,
        CT_BC5     = 3'd5,
        CT_BC7     = 3'd6
    } ctype_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXT     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_MIP  = 1'b1
    } back_state_t;

    // One work item handed from the front to the back.
    typedef struct packed {
        logic        is_desc;
        status_t     status;
        ctype_t      ctype;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] mip_req;
        logic [7:0]  byte_val;
        logic        last;
    } q_entry_t;

    function automatic ctype_t map_fourcc(input logic [31:0] f);
        ctype_t c;
        c = CT_UNKNOWN;
        if (f == FccDxt1) c = CT_BC1;
        else if (f == FccDxt2 || f == FccDxt3) c = CT_BC2;
        else if (f == FccDxt4 || f == FccDxt5) c = CT_BC3;
        else if (f == FccBc4u) c = CT_BC4;
        else if (f == FccBc5u) c = CT_BC5;
        else if (f == FccDxt7) c = CT_BC7;
        return c;
    endfunction

    function automatic ctype_t map_dxgi(input logic [31:0] g);
        ctype_t c;
        case (g)
            32'd71:  c = CT_BC1;
            32'd74:  c = CT_BC2;
            32'd77:  c = CT_BC3;
            32'd80:  c = CT_BC4;
            32'd83:  c = CT_BC5;
            32'd98:  c = CT_BC7;
            default: c = CT_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

/* rtl/dhp_front.sv */
// ----------------------------------------------------------------------------
// dhp_front
// Byte-level header parser: assembles words, runs all header checks and
// pushes one work item per result into the queue.
// ----------------------------------------------------------------------------
module dhp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               push,
    output dhp_pkg::q_entry_t  push_data
);

    logic [7:0]       pos_reg, pos_next;
    logic [31:0]      word_reg, word_next;
    dhp_pkg::phase_t  phase_reg, phase_next;
    logic [31:0]      width_reg, height_reg, mipreq_reg, hsize_reg, fsize_reg;
    logic [31:0]      flags_reg, fourcc_reg, dxgi_reg, dim_reg;

    dhp_pkg::status_t err;
    dhp_pkg::ctype_t  ctype;
    logic             fin, done, to_ext;

    assign word_next = {data_byte, word_reg[31:8]};

    always_comb
    begin
        err      = dhp_pkg::ST_OK;
        ctype    = dhp_pkg::CT_UNKNOWN;
        fin      = 1'b0;
        done     = 1'b0;
        to_ext   = 1'b0;
        push     = 1'b0;
        pos_next = pos_reg + 8'd1;
        push_data = '0;
        push_data.last = last_byte;
        if (phase_reg == dhp_pkg::PH_PAYLOAD) begin
            push = take;
            push_data.byte_val = data_byte;
        end else if (phase_reg != dhp_pkg::PH_ERROR) begin
            if (pos_reg == 8'd3 && word_next != dhp_pkg::FccMagic)
                err = dhp_pkg::ST_MAGIC;
            else if (pos_reg == 8'd127) begin
                if (hsize_reg != dhp_pkg::HeaderSize)
                    err = dhp_pkg::ST_HDR_SIZE;
                else if (fsize_reg != dhp_pkg::FormatSize)
                    err = dhp_pkg::ST_PF_SIZE;
                else if ((flags_reg & dhp_pkg::FlagFourcc) == '0)
                    err = dhp_pkg::ST_NO_FOURCC;
                else if (fourcc_reg == dhp_pkg::FccDx10)
                    to_ext = 1'b1;
                else begin
                    fin   = 1'b1;
                    ctype = dhp_pkg::map_fourcc(fourcc_reg);
                end
            end else if (pos_reg == 8'd147) begin
                if (dim_reg != dhp_pkg::DimTex2d)
                    err = dhp_pkg::ST_NOT_2D;
                else begin
                    fin   = 1'b1;
                    ctype = dhp_pkg::map_dxgi(dxgi_reg);
                end
            end
            if (fin) begin
                if (ctype == dhp_pkg::CT_UNKNOWN)
                    err = dhp_pkg::ST_FORMAT;
                else if (width_reg[1:0] != 2'b00 || height_reg[1:0] != 2'b00)
                    err = dhp_pkg::ST_DIMS;
                else
                    done = 1'b1;
            end
            if (err == dhp_pkg::ST_OK && !done && last_byte)
                err = dhp_pkg::ST_TRUNC;
            push = take && (done || err != dhp_pkg::ST_OK);
            push_data.is_desc = 1'b1;
            push_data.status  = err;
            if (done) begin
                push_data.ctype   = ctype;
                push_data.width   = width_reg;
                push_data.height  = height_reg;
                push_data.mip_req = mipreq_reg;
            end
        end

        if (phase_reg == dhp_pkg::PH_PAYLOAD || phase_reg == dhp_pkg::PH_ERROR)
            phase_next = phase_reg;
        else if (err != dhp_pkg::ST_OK)
            phase_next = dhp_pkg::PH_ERROR;
        else if (done)
            phase_next = dhp_pkg::PH_PAYLOAD;
        else if (to_ext)
            phase_next = dhp_pkg::PH_EXT;
        else
            phase_next = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            word_reg  <= '0;
            phase_reg <= dhp_pkg::PH_HEADER;
        end else if (take) begin
            if (last_byte) begin
                pos_reg   <= '0;
                word_reg  <= '0;
                phase_reg <= dhp_pkg::PH_HEADER;
            end else begin
                phase_reg <= phase_next;
                if (phase_reg == dhp_pkg::PH_HEADER || phase_reg == dhp_pkg::PH_EXT) begin
                    pos_reg  <= pos_next;
                    word_reg <= word_next;
                end
            end
        end
    end

    // Header fields land when their last byte arrives.
    always_ff @(posedge clk)
    begin
        if (take && (phase_reg == dhp_pkg::PH_HEADER || phase_reg == dhp_pkg::PH_EXT)) begin
            case (pos_reg)
                8'd7:    hsize_reg  <= word_next;
                8'd15:   height_reg <= word_next;
                8'd19:   width_reg  <= word_next;
                8'd31:   mipreq_reg <= word_next;
                8'd79:   fsize_reg  <= word_next;
                8'd83:   flags_reg  <= word_next;
                8'd87:   fourcc_reg <= word_next;
                8'd131:  dxgi_reg   <= word_next;
                8'd135:  dim_reg    <= word_next;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/dhp_queue.sv */
// ----------------------------------------------------------------------------
// dhp_queue
// Small first-in first-out buffer of work items between front and back.
// ----------------------------------------------------------------------------
module dhp_queue #(
    parameter int DEPTH = dhp_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dhp_pkg::q_entry_t  push_data,
    input  logic               pop,
    output dhp_pkg::q_entry_t  head,
    output logic               empty,
    output logic               full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    dhp_pkg::q_entry_t store [DEPTH];
    logic [PtrW-1:0]   wr_reg, rd_reg;
    logic [CntW-1:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CntW'(DEPTH));
    assign head  = store[rd_reg];

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= bump(wr_reg);
            if (pop)  rd_reg <= bump(rd_reg);
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) store[wr_reg] <= push_data;
    end

endmodule

/* rtl/dhp_back.sv */
// ----------------------------------------------------------------------------
// dhp_back
// Executes queued items: counts mip levels one level per cycle, forms the
// row stride and drives the registered result port.
// ----------------------------------------------------------------------------
module dhp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dhp_pkg::q_entry_t  head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_descriptor,
    output logic [3:0]         status,
    output logic [2:0]         color_type,
    output logic [31:0]        image_width_out,
    output logic [31:0]        image_height_out,
    output logic [31:0]        mip_levels,
    output logic [33:0]        row_stride,
    output logic [7:0]         payload_byte,
    output logic               last
);

    dhp_pkg::back_state_t state_reg, state_next;
    dhp_pkg::q_entry_t    job_reg;
    logic [31:0]          cw_reg, ch_reg, mips_reg;
    logic [5:0]           lvl_reg;
    logic                 ovalid_reg;
    dhp_pkg::q_entry_t    oent_reg;
    logic [31:0]          omips_reg;
    logic [33:0]          ostride_reg;

    logic                 slot_free, stop_req, stop_odd, both_zero, stopped;
    logic                 load, start;
    dhp_pkg::q_entry_t    src;
    logic [31:0]          src_mips;
    logic [29:0]          blocks;
    logic [33:0]          stride;

    assign slot_free = !ovalid_reg || out_ready;
    assign stop_req  = ({26'd0, lvl_reg} >= job_reg.mip_req);
    assign stop_odd  = ((cw_reg[1:0] | ch_reg[1:0]) != 2'b00);
    assign both_zero = (cw_reg == '0) && (ch_reg == '0);
    assign stopped   = stop_req || stop_odd || both_zero;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        start      = 1'b0;
        src        = head;
        src_mips   = 32'd1;
        unique case (state_reg)
            dhp_pkg::BK_IDLE:
            begin
                if (!empty && slot_free) begin
                    pop = 1'b1;
                    if (head.is_desc && head.status == dhp_pkg::ST_OK
                        && head.mip_req > 32'd1) begin
                        start      = 1'b1;
                        state_next = dhp_pkg::BK_MIP;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            dhp_pkg::BK_MIP:
            begin
                src = job_reg;
                if (stop_req || stop_odd)
                    src_mips = mips_reg;
                else
                    src_mips = job_reg.mip_req;
                if (stopped && slot_free) begin
                    load       = 1'b1;
                    state_next = dhp_pkg::BK_IDLE;
                end
            end
            default: state_next = dhp_pkg::BK_IDLE;
        endcase
    end

    // Width is a multiple of four here, so the block count is a plain shift.
    assign blocks = (src.width[31:2] == '0) ? 30'd1 : src.width[31:2];
    assign stride = (src.ctype == dhp_pkg::CT_BC1 || src.ctype == dhp_pkg::CT_BC4)
                    ? {1'b0, blocks, 3'b000} : {blocks, 4'b0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= dhp_pkg::BK_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load)           ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            job_reg  <= head;
            cw_reg   <= head.width;
            ch_reg   <= head.height;
            mips_reg <= 32'd1;
            lvl_reg  <= '0;
        end else if (state_reg == dhp_pkg::BK_MIP && !stopped) begin
            cw_reg   <= cw_reg >> 1;
            ch_reg   <= ch_reg >> 1;
            mips_reg <= {26'd0, lvl_reg} + 32'd1;
            lvl_reg  <= lvl_reg + 6'd1;
        end
        if (load) begin
            oent_reg <= src;
            if (src.is_desc && src.status == dhp_pkg::ST_OK) begin
                omips_reg   <= src_mips;
                ostride_reg <= stride;
            end else begin
                omips_reg   <= '0;
                ostride_reg <= '0;
            end
        end
    end

    assign out_valid        = ovalid_reg;
    assign is_descriptor    = oent_reg.is_desc;
    assign status           = oent_reg.status;
    assign color_type       = oent_reg.ctype;
    assign image_width_out  = oent_reg.width;
    assign image_height_out = oent_reg.height;
    assign mip_levels       = omips_reg;
    assign row_stride       = ostride_reg;
    assign payload_byte     = oent_reg.byte_val;
    assign last             = oent_reg.last;

endmodule

/* rtl/dds_header_parser.sv */
// ----------------------------------------------------------------------------
// dds_header_parser
// Parses a DDS texture file streamed one byte per transfer and emits one
// descriptor followed by the payload bytes, or a single error report.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Payload
// input     in_valid / in_ready   data_byte, last_byte
// output    out_valid / out_ready is_descriptor, status, color_type,
//                                 image_width_out, image_height_out,
//                                 mip_levels, row_stride, payload_byte, last
//
// The front accepts one byte per cycle whenever the work queue has room, so
// header and payload bytes stream at one transfer per cycle.
// A valid descriptor with a mip request above one occupies the back end
// while the mip count is found, one level per cycle; the
// queue absorbs up to QUEUE_DEPTH further results meanwhile, and in_ready
// drops once it is full.
// Reset is asynchronous and active low; the parser then waits for byte zero.
// A stall on the output fills the queue and then drops in_ready.
//
module dds_header_parser #(
    parameter int QUEUE_DEPTH = dhp_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_descriptor,
    output logic [3:0]  status,
    output logic [2:0]  color_type,
    output logic [31:0] image_width_out,
    output logic [31:0] image_height_out,
    output logic [31:0] mip_levels,
    output logic [33:0] row_stride,
    output logic [7:0]  payload_byte,
    output logic        last
);

    logic              take, push, pop, q_empty, q_full;
    dhp_pkg::q_entry_t push_data, head;

    // A byte is taken only when the queue can hold whatever it produces.
    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    dhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_data (push_data)
    );

    dhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    dhp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (q_empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_descriptor    (is_descriptor),
        .status           (status),
        .color_type       (color_type),
        .image_width_out  (image_width_out),
        .image_height_out (image_height_out),
        .mip_levels       (mip_levels),
        .row_stride       (row_stride),
        .payload_byte     (payload_byte),
        .last             (last)
    );

endmodule

/* sim/dds_header_parser_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dds_header_parser_checker
// Watches both channels of the DDS header parser, predicts the result of
// every input transfer and compares each output transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module dds_header_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        is_descriptor,
    input  logic [3:0]  status,
    input  logic [2:0]  color_type,
    input  logic [31:0] image_width_out,
    input  logic [31:0] image_height_out,
    input  logic [31:0] mip_levels,
    input  logic [33:0] row_stride,
    input  logic [7:0]  payload_byte,
    input  logic        last,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic        desc;
        logic [3:0]  st;
        logic [2:0]  ct;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] mips;
        logic [33:0] stride;
        logic [7:0]  pb;
        logic        lst;
    } parse_result_t;

    parse_result_t expected_results[$];

    // Parser state as the byte stream sees it.
    logic [7:0]       pos;
    logic [31:0]      word;
    dhp_pkg::phase_t  phase;
    logic [31:0] hdr_w, hdr_h, hdr_mips, hdr_size, pf_size, pf_flags, fourcc, dxgi, dim;

    task automatic clear_state();
        pos = '0; word = '0; phase = dhp_pkg::PH_HEADER;
        hdr_w = '0; hdr_h = '0; hdr_mips = '0; hdr_size = '0; pf_size = '0;
        pf_flags = '0; fourcc = '0; dxgi = '0; dim = '0;
    endtask

    function automatic dhp_pkg::ctype_t fourcc_color(logic [31:0] f);
        dhp_pkg::ctype_t c;
        c = dhp_pkg::CT_UNKNOWN;
        case (f)
            dhp_pkg::FccDxt1:                   c = dhp_pkg::CT_BC1;
            dhp_pkg::FccDxt2, dhp_pkg::FccDxt3: c = dhp_pkg::CT_BC2;
            dhp_pkg::FccDxt4, dhp_pkg::FccDxt5: c = dhp_pkg::CT_BC3;
            dhp_pkg::FccBc4u:                   c = dhp_pkg::CT_BC4;
            dhp_pkg::FccBc5u:                   c = dhp_pkg::CT_BC5;
            dhp_pkg::FccDxt7:                   c = dhp_pkg::CT_BC7;
            default:                            c = dhp_pkg::CT_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic dhp_pkg::ctype_t dxgi_color(logic [31:0] g);
        dhp_pkg::ctype_t c;
        c = dhp_pkg::CT_UNKNOWN;
        if (g == 32'd71) c = dhp_pkg::CT_BC1;
        else if (g == 32'd74) c = dhp_pkg::CT_BC2;
        else if (g == 32'd77) c = dhp_pkg::CT_BC3;
        else if (g == 32'd80) c = dhp_pkg::CT_BC4;
        else if (g == 32'd83) c = dhp_pkg::CT_BC5;
        else if (g == 32'd98) c = dhp_pkg::CT_BC7;
        return c;
    endfunction

    // Final checks of a header; builds the descriptor when they pass.
    task automatic build_descriptor(input dhp_pkg::ctype_t ct, output dhp_pkg::status_t st,
                                    output parse_result_t r);
        logic [31:0] cw, ch, mips;
        logic [63:0] blocks, blk;
        longint      i;
        r = '0;
        st = dhp_pkg::ST_OK;
        if (ct == dhp_pkg::CT_UNKNOWN) st = dhp_pkg::ST_FORMAT;
        else if ((hdr_w[1:0] != 0) || (hdr_h[1:0] != 0)) st = dhp_pkg::ST_DIMS;
        else begin
            mips = 1;
            if (hdr_mips > 1) begin
                cw = hdr_w;
                ch = hdr_h;
                for (i = 0; i < hdr_mips; i++) begin
                    if (((cw | ch) & 32'h3) != 0) break;
                    if (cw == 0 && ch == 0) begin
                        mips = hdr_mips;
                        break;
                    end
                    cw = cw >> 1;
                    ch = ch >> 1;
                    mips = 32'(i + 1);
                end
            end
            blk = (ct == dhp_pkg::CT_BC1 || ct == dhp_pkg::CT_BC4) ? 64'd8 : 64'd16;
            blocks = ({32'd0, hdr_w} + 64'd3) / 64'd4;
            if (blocks < 1) blocks = 1;
            r.desc = 1'b1;
            r.ct = ct;
            r.w = hdr_w;
            r.h = hdr_h;
            r.mips = mips;
            r.stride = 34'(blocks * blk);
            phase = dhp_pkg::PH_PAYLOAD;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic lb);
        parse_result_t    r;
        dhp_pkg::status_t err, st;
        logic             have;
        r = '0;
        have = 1'b0;
        err = dhp_pkg::ST_OK;
        if (phase == dhp_pkg::PH_PAYLOAD) begin
            r.pb = b;
            have = 1'b1;
        end else if (phase != dhp_pkg::PH_ERROR) begin
            word = {b, word[31:8]};
            case (pos)
                8'd3:   if (word != dhp_pkg::FccMagic) err = dhp_pkg::ST_MAGIC;
                8'd7:   hdr_size = word;
                8'd15:  hdr_h = word;
                8'd19:  hdr_w = word;
                8'd31:  hdr_mips = word;
                8'd79:  pf_size = word;
                8'd83:  pf_flags = word;
                8'd87:  fourcc = word;
                8'd131: dxgi = word;
                8'd135: dim = word;
                default: ;
            endcase
            if (err == dhp_pkg::ST_OK && pos == 8'd127) begin
                if (hdr_size != dhp_pkg::HeaderSize) err = dhp_pkg::ST_HDR_SIZE;
                else if (pf_size != dhp_pkg::FormatSize) err = dhp_pkg::ST_PF_SIZE;
                else if ((pf_flags & dhp_pkg::FlagFourcc) == 0) err = dhp_pkg::ST_NO_FOURCC;
                else if (fourcc == dhp_pkg::FccDx10) phase = dhp_pkg::PH_EXT;
                else begin
                    build_descriptor(fourcc_color(fourcc), st, r);
                    err = st;
                    have = (st == dhp_pkg::ST_OK);
                end
            end else if (err == dhp_pkg::ST_OK && pos == 8'd147) begin
                if (dim != dhp_pkg::DimTex2d) err = dhp_pkg::ST_NOT_2D;
                else begin
                    build_descriptor(dxgi_color(dxgi), st, r);
                    err = st;
                    have = (st == dhp_pkg::ST_OK);
                end
            end
            pos = pos + 8'd1;
            // An error on this byte outranks truncation by the last byte.
            if (err == dhp_pkg::ST_OK && !have && lb) err = dhp_pkg::ST_TRUNC;
            if (err != dhp_pkg::ST_OK) begin
                r = '0;
                r.desc = 1'b1;
                r.st = err;
                phase = dhp_pkg::PH_ERROR;
                have = 1'b1;
            end
        end
        if (have) begin
            r.lst = lb;
            expected_results.push_back(r);
        end
        if (lb) clear_state();
    endtask

    task automatic compare_result();
        parse_result_t e, a;
        a = '{is_descriptor, status, color_type, image_width_out, image_height_out,
              mip_levels, row_stride, payload_byte, last};
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result transfer %p", $realtime, a);
        end else begin
            e = expected_results.pop_front();
            if (a !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                             $realtime, e, a);
            end
        end
    endtask

    initial begin
        mismatches = 0;
        clear_state();
    end

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_state();
            expected_results.delete();
        end else begin
            if (in_valid && in_ready) predict_byte(data_byte, last_byte);
            if (out_valid && out_ready) compare_result();
        end
    end

endmodule

/* sim/dds_header_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dds_header_parser_tb
// Streams directed and random DDS files into the header parser under several
// idling patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module dds_header_parser_tb;

    localparam int CycleLimit = 2000000;
    localparam int ByteTarget = 1700;
    localparam int DrainCycles = 60;

    // Kinds of generated file.
    localparam int FileFourcc    = 0;
    localparam int FileDx10      = 1;
    localparam int FileBadMagic  = 2;
    localparam int FileBadHdr    = 3;
    localparam int FileBadPf     = 4;
    localparam int FileNoFourcc  = 5;
    localparam int FileNot2d     = 6;
    localparam int FileBadFormat = 7;
    localparam int FileBadDims   = 8;
    localparam int FileTruncated = 9;
    localparam int FileNoise     = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        is_descriptor;
    logic [3:0]  status;
    logic [2:0]  color_type;
    logic [31:0] image_width_out;
    logic [31:0] image_height_out;
    logic [31:0] mip_levels;
    logic [33:0] row_stride;
    logic [7:0]  payload_byte;
    logic        last;
    int          mismatches;
    int          pending;

    // Percentages of idle cycles on the sender and of stalls on the receiver.
    int          gap_pct;
    int          stall_pct;
    int          cycles;
    int          bytes_sent;

    // The file being built before it is streamed.
    logic [7:0]  file_buf[$];

    logic [31:0] fourcc_codes[8] = '{dhp_pkg::FccDxt1, dhp_pkg::FccDxt2, dhp_pkg::FccDxt3,
                                     dhp_pkg::FccDxt4, dhp_pkg::FccDxt5, dhp_pkg::FccBc4u,
                                     dhp_pkg::FccBc5u, dhp_pkg::FccDxt7};
    logic [31:0] dxgi_codes[6] = '{32'd71, 32'd74, 32'd77, 32'd80, 32'd83, 32'd98};

    dds_header_parser DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_descriptor(is_descriptor), .status(status), .color_type(color_type),
        .image_width_out(image_width_out), .image_height_out(image_height_out),
        .mip_levels(mip_levels), .row_stride(row_stride),
        .payload_byte(payload_byte), .last(last)
    );

    dds_header_parser_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_descriptor(is_descriptor), .status(status), .color_type(color_type),
        .image_width_out(image_width_out), .image_height_out(image_height_out),
        .mip_levels(mip_levels), .row_stride(row_stride),
        .payload_byte(payload_byte), .last(last),
        .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Writes a little-endian word at a byte offset of the file buffer.
    task automatic put_word(input int offs, input logic [31:0] val);
        for (int i = 0; i < 4; i++)
            file_buf[offs + i] = val[8*i +: 8];
    endtask

    // Picks a width or height: mostly small multiples of four, now and then
    // the extremes of the field.
    function automatic logic [31:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return 32'(4 * $urandom_range(0, 40));
        if (sel < 85) return 32'hFFFF_FFFC;
        if (sel < 90) return 32'd0;
        return $urandom & 32'hFFFF_FFFC;
    endfunction

    function automatic logic [31:0] pick_mips();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 32'($urandom_range(0, 12));
        if (sel < 80) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Builds one file of the given kind. The selector picks a format code,
    // and the payload length follows the header.
    task automatic make_file(input int kind, input int sel, input int payload_len);
        logic [31:0] w, h;
        int          hdr_len;
        file_buf.delete();
        hdr_len = (kind == FileDx10 || kind == FileNot2d) ? 148 : 128;
        if (kind == FileBadFormat && sel[0]) hdr_len = 148;
        for (int i = 0; i < hdr_len + payload_len; i++)
            file_buf.push_back(8'($urandom));
        if (kind == FileNoise) return;
        w = pick_dim();
        h = pick_dim();
        put_word(0, dhp_pkg::FccMagic);
        put_word(4, dhp_pkg::HeaderSize);
        put_word(12, h);
        put_word(16, w);
        put_word(28, pick_mips());
        put_word(76, dhp_pkg::FormatSize);
        put_word(80, $urandom | dhp_pkg::FlagFourcc);
        put_word(84, fourcc_codes[sel % 8]);
        if (hdr_len == 148) begin
            put_word(84, dhp_pkg::FccDx10);
            put_word(128, dxgi_codes[sel % 6]);
            put_word(132, dhp_pkg::DimTex2d);
        end
        case (kind)
            FileBadMagic:  file_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            FileBadHdr:    put_word(4, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd123);
            FileBadPf:     put_word(76, $urandom_range(0, 1) ? 32'd0 : 32'd33);
            FileNoFourcc:  put_word(80, $urandom & ~dhp_pkg::FlagFourcc);
            FileNot2d:     put_word(132, $urandom_range(0, 1) ? 32'd2 : $urandom);
            // "DXT6" is not a known code.
            FileBadFormat: put_word(hdr_len == 148 ? 128 : 84,
                                    $urandom_range(0, 1) ? 32'd72
                                                         : dhp_pkg::FccDxt2 + 32'h0400_0000);
            FileBadDims:   put_word($urandom_range(0, 1) ? 12 : 16, w | 32'($urandom_range(1, 3)));
            FileTruncated: file_buf = file_buf[0 : $urandom_range(0, hdr_len - 2)];
            default: ;
        endcase
    endtask

    // Drives one byte and holds it until the transfer; idles afterwards at
    // the rate of the current phase.
    task automatic send_byte(input logic [7:0] b, input logic lb);
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lb;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_file();
        foreach (file_buf[i])
            send_byte(file_buf[i], i == file_buf.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_ready = 1'b0;
        cycles = 0;
        bytes_sent = 0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files: a header that ends on the last byte, and a file
        // cut short after its first byte.
        make_file(FileFourcc, 0, 0);
        send_file();
        make_file(FileTruncated, 0, 0);
        file_buf = file_buf[0:0];
        send_file();

        // Hold the sender until every expected result has arrived.
        wait_drained();

        // Random files over four idling phases.
        while (bytes_sent < ByteTarget) begin
            case ((bytes_sent * 4) / ByteTarget)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 70; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 70; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 45) kind = FileFourcc;
            else if (sel < 70) kind = FileDx10;
            else kind = $urandom_range(FileBadMagic, FileNoise);
            make_file(kind, $urandom_range(0, 47), $urandom_range(0, 24));
            send_file();
        end

        wait_drained();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/dhp_pkg.sv
rtl/dhp_front.sv
rtl/dhp_queue.sv
rtl/dhp_back.sv
rtl/dds_header_parser.sv
sim/dds_header_parser_checker.sv
sim/dds_header_parser_tb.sv
